/* hdl/srts_pkg.sv */
// ----------------------------------------------------------------------------
// srts_pkg
// Shared types, constants and helpers for the shortest remaining time
// scheduler: action codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package srts_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int TIME_W       = 16;
  localparam int IDX_W        = 4;
  localparam int PC_W         = 5;
  localparam int ACT_W        = 2;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PC_W-1:0]   pcount_t;
  typedef logic [ACT_W-1:0]  action_t;

  localparam pcount_t PC_RESET = pcount_t'(16);

  localparam action_t ACT_LOAD    = 2'd0;
  localparam action_t ACT_TICK    = 2'd1;
  localparam action_t ACT_RESTART = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_EMIT,
    ST_SWEEP,
    ST_SWEEP_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic tick_start;
    logic restart_start;
    logic scan_step;
    logic sweep_step;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic all_done;
    logic scan_last;
    logic sweep_last;
    logic out_free;
  } status_t;

  function automatic time_t sat_inc(time_t v);
    return (v == '1) ? v : v + time_t'(1);
  endfunction

endpackage

/* hdl/srts_ctrl.sv */
// ----------------------------------------------------------------------------
// srts_ctrl
// Controller state machine. Decodes each accepted transaction and steps the
// datapath through the table scan, the update, the result hand-off and the
// restart sweep.
// ----------------------------------------------------------------------------
module srts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srts_pkg::action_t action,
  input  srts_pkg::status_t status,
  output srts_pkg::cmd_t    cmd
);

  srts_pkg::state_t state;
  srts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srts_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (action)
            srts_pkg::ACT_TICK: begin
              state_next = status.all_done ? srts_pkg::ST_EMIT : srts_pkg::ST_SCAN;
            end
            srts_pkg::ACT_RESTART: begin
              state_next = srts_pkg::ST_SWEEP;
            end
            default: begin
              state_next = srts_pkg::ST_IDLE;
            end
          endcase
        end
      end
      srts_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = srts_pkg::ST_DRAIN;
        end
      end
      srts_pkg::ST_DRAIN: begin
        state_next = srts_pkg::ST_UPDATE;
      end
      srts_pkg::ST_UPDATE: begin
        state_next = srts_pkg::ST_EMIT;
      end
      srts_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = srts_pkg::ST_IDLE;
        end
      end
      srts_pkg::ST_SWEEP: begin
        if (status.sweep_last) begin
          state_next = srts_pkg::ST_SWEEP_DRAIN;
        end
      end
      srts_pkg::ST_SWEEP_DRAIN: begin
        state_next = srts_pkg::ST_IDLE;
      end
      default: begin
        state_next = srts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      srts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (action)
            srts_pkg::ACT_LOAD:    cmd.load          = 1'b1;
            srts_pkg::ACT_TICK:    cmd.tick_start    = 1'b1;
            srts_pkg::ACT_RESTART: cmd.restart_start = 1'b1;
            default: begin
            end
          endcase
        end
      end
      srts_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      srts_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      srts_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      srts_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/srts_datapath.sv */
// ----------------------------------------------------------------------------
// srts_datapath
// Job table memories, done marks, time register, the running minimum search
// over the table, the completion arithmetic and the result register.
// ----------------------------------------------------------------------------
module srts_datapath #(
  parameter int MAX_JOBS = srts_pkg::MAX_JOBS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  srts_pkg::cmd_t    cmd,
  output srts_pkg::status_t status,
  input  logic              cfg_we,
  input  srts_pkg::pcount_t cfg_data,
  input  srts_pkg::idx_t    entry_index,
  input  srts_pkg::time_t   arrival_time,
  input  srts_pkg::time_t   burst_time,
  output logic              out_valid,
  input  logic              out_ready,
  output srts_pkg::time_t   slot_time,
  output srts_pkg::idx_t    run_index,
  output logic              idle,
  output logic              finished,
  output srts_pkg::time_t   completion_time,
  output srts_pkg::time_t   turnaround,
  output srts_pkg::time_t   waiting,
  output logic              all_done
);

  localparam int JW = $clog2(MAX_JOBS);
  typedef logic [JW-1:0] job_idx_t;

  srts_pkg::time_t arrival_mem   [MAX_JOBS];
  srts_pkg::time_t burst_mem     [MAX_JOBS];
  srts_pkg::time_t remaining_mem [MAX_JOBS];

  logic [MAX_JOBS-1:0] done;
  logic [MAX_JOBS-1:0] loaded;
  logic [MAX_JOBS-1:0] active;

  srts_pkg::pcount_t process_count;
  srts_pkg::time_t   sched_time;
  srts_pkg::time_t   slot;

  job_idx_t        scan_idx;
  job_idx_t        cmp_idx;
  logic            cmp_pend;
  logic            sweep_pend;
  srts_pkg::time_t arr_rd;
  srts_pkg::time_t bur_rd;
  srts_pkg::time_t rem_rd;

  logic            found;
  job_idx_t        best_idx;
  srts_pkg::time_t best_rem;
  srts_pkg::time_t best_arr;
  srts_pkg::time_t best_bur;

  logic            fin;
  srts_pkg::time_t comp;
  srts_pkg::time_t tat;

  logic            load_ok;
  job_idx_t        load_addr;
  logic            eligible;
  logic            better;
  srts_pkg::time_t bur_eff;
  logic            upd_fin;
  srts_pkg::time_t upd_comp;
  logic            all_done_now;
  srts_pkg::time_t wait_val;

  logic            rem_we;
  job_idx_t        rem_waddr;
  srts_pkg::time_t rem_wdata;

  assign load_addr = job_idx_t'(entry_index);
  assign load_ok   = cmd.load && (int'(entry_index) < MAX_JOBS);
  assign eligible  = cmp_pend && !done[cmp_idx] && (arr_rd <= slot);
  assign better    = eligible && (!found || (rem_rd < best_rem));
  assign bur_eff   = loaded[cmp_idx] ? bur_rd : '0;
  assign upd_fin   = found && (best_rem == srts_pkg::time_t'(1));
  assign upd_comp  = srts_pkg::sat_inc(slot);
  assign wait_val  = (tat >= best_bur) ? tat - best_bur : '0;

  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      active[i] = int'(process_count) > i;
    end
  end

  assign all_done_now = &(done | ~active);

  assign status.all_done   = all_done_now;
  assign status.scan_last  = (int'(scan_idx) + 1 >= int'(process_count)) ||
                             (int'(scan_idx) == MAX_JOBS - 1);
  assign status.sweep_last = (int'(scan_idx) == MAX_JOBS - 1);
  assign status.out_free   = !out_valid || out_ready;

  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = load_addr;
    rem_wdata = burst_time;
    if (load_ok) begin
      rem_we = 1'b1;
    end else if (sweep_pend) begin
      rem_we    = 1'b1;
      rem_waddr = cmp_idx;
      rem_wdata = bur_eff;
    end else if (cmd.update && found) begin
      rem_we    = 1'b1;
      rem_waddr = best_idx;
      rem_wdata = best_rem - srts_pkg::time_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      arrival_mem[load_addr] <= arrival_time;
      burst_mem[load_addr]   <= burst_time;
    end
    if (rem_we) begin
      remaining_mem[rem_waddr] <= rem_wdata;
    end
    arr_rd <= arrival_mem[scan_idx];
    bur_rd <= burst_mem[scan_idx];
    rem_rd <= remaining_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= srts_pkg::PC_RESET;
      sched_time    <= '0;
      done          <= '1;
      loaded        <= '0;
      scan_idx      <= '0;
      cmp_pend      <= 1'b0;
      sweep_pend    <= 1'b0;
      found         <= 1'b0;
      fin           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        process_count <= cfg_data;
      end
      cmp_pend   <= cmd.scan_step;
      sweep_pend <= cmd.sweep_step;
      if (cmd.tick_start || cmd.restart_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_step || cmd.sweep_step) begin
        scan_idx <= scan_idx + job_idx_t'(1);
      end
      if (cmd.restart_start) begin
        sched_time <= '0;
      end else if (cmd.update) begin
        sched_time <= srts_pkg::sat_inc(sched_time);
      end
      if (load_ok) begin
        loaded[load_addr] <= 1'b1;
        done[load_addr]   <= (burst_time == '0);
      end
      if (sweep_pend) begin
        done[cmp_idx] <= (bur_eff == '0);
      end
      if (cmd.update && upd_fin) begin
        done[best_idx] <= 1'b1;
      end
      if (cmd.tick_start) begin
        found <= 1'b0;
        fin   <= 1'b0;
      end else begin
        if (better) begin
          found <= 1'b1;
        end
        if (cmd.update) begin
          fin <= upd_fin;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      slot <= sched_time;
    end
    if (cmd.scan_step || cmd.sweep_step) begin
      cmp_idx <= scan_idx;
    end
    if (better) begin
      best_idx <= cmp_idx;
      best_rem <= rem_rd;
      best_arr <= arr_rd;
      best_bur <= bur_rd;
    end
    if (cmd.update) begin
      comp <= upd_fin ? upd_comp : '0;
      tat  <= upd_fin ? upd_comp - best_arr : '0;
    end
    if (cmd.emit) begin
      slot_time       <= slot;
      run_index       <= found ? srts_pkg::idx_t'(best_idx) : '0;
      idle            <= !found;
      finished        <= fin;
      completion_time <= fin ? comp : '0;
      turnaround      <= fin ? tat : '0;
      waiting         <= fin ? wait_val : '0;
      all_done        <= all_done_now;
    end
  end

endmodule

/* hdl/shortest_remaining_time_scheduler.sv */
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Load and unused-action transactions are taken in the idle state and end
// there. A tick scans the first min(process_count, MAX_JOBS) table entries,
// reading one table entry per cycle through the memory read port; a tick
// with every job done skips the scan. A restart sweeps all MAX_JOBS entries.
// Synchronous reset empties the table, zeroes time and sets the count to 16.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler #(
  parameter int MAX_JOBS = srts_pkg::MAX_JOBS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  srts_pkg::pcount_t cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  srts_pkg::action_t action,
  input  srts_pkg::idx_t    entry_index,
  input  srts_pkg::time_t   arrival_time,
  input  srts_pkg::time_t   burst_time,
  output logic              out_valid,
  input  logic              out_ready,
  output srts_pkg::time_t   slot_time,
  output srts_pkg::idx_t    run_index,
  output logic              idle,
  output logic              finished,
  output srts_pkg::time_t   completion_time,
  output srts_pkg::time_t   turnaround,
  output srts_pkg::time_t   waiting,
  output logic              all_done
);

  srts_pkg::cmd_t    cmd;
  srts_pkg::status_t status;

  srts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  srts_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .entry_index     (entry_index),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .slot_time       (slot_time),
    .run_index       (run_index),
    .idle            (idle),
    .finished        (finished),
    .completion_time (completion_time),
    .turnaround      (turnaround),
    .waiting         (waiting),
    .all_done        (all_done)
  );

endmodule

/* verif/shortest_remaining_time_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_tb
// Self-checking bench for the preemptive shortest remaining time scheduler.
// A scoreboard class keeps its own job table, time and count and predicts
// every tick result. A directed opening covers empty tables, ties,
// preemption, zero bursts, the unused action, loads during a schedule and
// count extremes. Random schedules follow, with bursts of idling on both
// channels. A final idle-free pass runs a short schedule to completion.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                JOBS       = srts_pkg::MAX_JOBS_DEF;
  localparam int                CYCLE_MAX  = 2_000_000;
  localparam int                SETTLE     = 40;
  localparam int                ITEM_GOAL  = 1600;
  localparam srts_pkg::action_t ACT_UNUSED = 2'd3;

  typedef struct packed {
    srts_pkg::time_t slot;
    srts_pkg::idx_t  run;
    logic            idle;
    logic            fin;
    srts_pkg::time_t comp;
    srts_pkg::time_t tat;
    srts_pkg::time_t wait_ticks;
    logic            all_done;
  } tick_result_t;

  class srtf_scoreboard;
    srts_pkg::time_t   arrival_tab[JOBS];
    srts_pkg::time_t   burst_tab[JOBS];
    srts_pkg::time_t   remain_tab[JOBS];
    bit                done_tab[JOBS];
    srts_pkg::time_t   clock_now;
    srts_pkg::pcount_t count;
    tick_result_t      expected_q[$];
    int                errors;
    int                ticks;
    int                idles;
    int                finishes;
    int                loads;
    int                restarts;

    function new();
      int i;
      for (i = 0; i < JOBS; i++) begin
        arrival_tab[i] = '0;
        burst_tab[i] = '0;
        remain_tab[i] = '0;
        done_tab[i] = 1'b1;
      end
      clock_now = '0;
      count = srts_pkg::PC_RESET;
      errors = 0;
      ticks = 0;
      idles = 0;
      finishes = 0;
      loads = 0;
      restarts = 0;
    endfunction

    function int active();
      return (count > JOBS) ? JOBS : int'(count);
    endfunction

    function bit all_jobs_done();
      int i;
      for (i = 0; i < active(); i++)
        if (!done_tab[i]) return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(srts_pkg::action_t act, srts_pkg::idx_t idx,
                             srts_pkg::time_t arr, srts_pkg::time_t bur);
      tick_result_t r;
      int           i;
      int           pick;
      bit           found;
      r = '0;
      pick = 0;
      found = 1'b0;
      if (act == srts_pkg::ACT_LOAD) begin
        arrival_tab[idx] = arr;
        burst_tab[idx] = bur;
        remain_tab[idx] = bur;
        done_tab[idx] = (bur == 0);
        loads++;
      end else if (act == srts_pkg::ACT_RESTART) begin
        clock_now = '0;
        for (i = 0; i < JOBS; i++) begin
          remain_tab[i] = burst_tab[i];
          done_tab[i] = (burst_tab[i] == 0);
        end
        restarts++;
      end else if (act == srts_pkg::ACT_TICK) begin
        r.slot = clock_now;
        if (!all_jobs_done()) begin
          for (i = 0; i < active(); i++) begin
            if (arrival_tab[i] <= r.slot && !done_tab[i] &&
                (!found || remain_tab[i] < remain_tab[pick])) begin
              found = 1'b1;
              pick = i;
            end
          end
          if (clock_now != 16'hFFFF) clock_now = clock_now + 16'd1;
          if (found) begin
            remain_tab[pick] = remain_tab[pick] - 16'd1;
            if (remain_tab[pick] == 0) begin
              done_tab[pick] = 1'b1;
              r.fin = 1'b1;
              r.comp = (r.slot == 16'hFFFF) ? r.slot : r.slot + 16'd1;
              r.tat = r.comp - arrival_tab[pick];
              r.wait_ticks = (r.tat >= burst_tab[pick]) ? r.tat - burst_tab[pick] : '0;
              finishes++;
            end
          end
        end
        r.run = found ? srts_pkg::idx_t'(pick) : '0;
        r.idle = !found;
        r.all_done = all_jobs_done();
        if (!found) idles++;
        ticks++;
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        if (errors <= 60)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 60)
          $display("%0t: unexpected result, expected none, actual slot %0d run %0d",
                   $time, got.slot, got.run);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("slot_time", exp_r.slot, got.slot);
      compare_field("run_index", exp_r.run, got.run);
      compare_field("idle", exp_r.idle, got.idle);
      compare_field("finished", exp_r.fin, got.fin);
      compare_field("completion_time", exp_r.comp, got.comp);
      compare_field("turnaround", exp_r.tat, got.tat);
      compare_field("waiting", exp_r.wait_ticks, got.wait_ticks);
      compare_field("all_done", exp_r.all_done, got.all_done);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  srts_pkg::pcount_t cfg_data;
  logic              in_valid;
  logic              in_ready;
  srts_pkg::action_t action;
  srts_pkg::idx_t    entry_index;
  srts_pkg::time_t   arrival_time;
  srts_pkg::time_t   burst_time;
  logic              out_valid;
  logic              out_ready;
  srts_pkg::time_t   slot_time;
  srts_pkg::idx_t    run_index;
  logic              idle;
  logic              finished;
  srts_pkg::time_t   completion_time;
  srts_pkg::time_t   turnaround;
  srts_pkg::time_t   waiting;
  logic              all_done;

  srtf_scoreboard sb;
  bit             idling_on;
  int             items_sent;
  int             cfg_writes;
  int             cycles;

  shortest_remaining_time_scheduler u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .entry_index    (entry_index),
    .arrival_time   (arrival_time),
    .burst_time     (burst_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .slot_time      (slot_time),
    .run_index      (run_index),
    .idle           (idle),
    .finished       (finished),
    .completion_time(completion_time),
    .turnaround     (turnaround),
    .waiting        (waiting),
    .all_done       (all_done)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    tick_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.slot = slot_time;
      got.run = run_index;
      got.idle = idle;
      got.fin = finished;
      got.comp = completion_time;
      got.tat = turnaround;
      got.wait_ticks = waiting;
      got.all_done = all_done;
      sb.check_result(got);
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_item(srts_pkg::action_t act, srts_pkg::idx_t idx,
                           srts_pkg::time_t arr, srts_pkg::time_t bur);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    entry_index <= idx;
    arrival_time <= arr;
    burst_time <= bur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(act, idx, arr, bur);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic tick_job();
    send_item(srts_pkg::ACT_TICK, srts_pkg::idx_t'($urandom), srts_pkg::time_t'($urandom),
              srts_pkg::time_t'($urandom));
  endtask

  task automatic load_job(srts_pkg::idx_t idx, srts_pkg::time_t arr, srts_pkg::time_t bur);
    send_item(srts_pkg::ACT_LOAD, idx, arr, bur);
  endtask

  task automatic restart_jobs();
    send_item(srts_pkg::ACT_RESTART, srts_pkg::idx_t'($urandom), srts_pkg::time_t'($urandom),
              srts_pkg::time_t'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(srts_pkg::pcount_t value);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.count = value;
    cfg_writes++;
  endtask

  function automatic srts_pkg::time_t pick_arrival();
    return ($urandom_range(0, 9) == 0) ? srts_pkg::time_t'($urandom) :
                                         srts_pkg::time_t'($urandom_range(0, 24));
  endfunction

  function automatic srts_pkg::time_t pick_burst();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return srts_pkg::time_t'($urandom);
    if (sel == 2) return 16'hFFFF;
    return srts_pkg::time_t'($urandom_range(1, 10));
  endfunction

  task automatic run_schedule();
    int                sel;
    int                guard;
    srts_pkg::pcount_t cnt;
    idling_on = ($urandom_range(0, 3) != 0);
    sel = $urandom_range(0, 19);
    if (sel == 0) cnt = '0;
    else if (sel < 3) cnt = srts_pkg::pcount_t'($urandom_range(17, 31));
    else cnt = srts_pkg::pcount_t'($urandom_range(1, 16));
    if ($urandom_range(0, 1) == 0) write_count(cnt);
    repeat ($urandom_range(1, 16))
      load_job(srts_pkg::idx_t'($urandom), pick_arrival(), pick_burst());
    if ($urandom_range(0, 2) != 0) restart_jobs();
    guard = 0;
    while (!sb.all_jobs_done() && guard < 200) begin
      sel = $urandom_range(0, 49);
      if (sel == 0) load_job(srts_pkg::idx_t'($urandom), pick_arrival(), pick_burst());
      else if (sel == 1) restart_jobs();
      else if (sel == 2) send_item(ACT_UNUSED, srts_pkg::idx_t'($urandom),
                                   srts_pkg::time_t'($urandom), srts_pkg::time_t'($urandom));
      else tick_job();
      guard++;
    end
    repeat ($urandom_range(1, 3)) tick_job();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    items_sent = 0;
    cfg_writes = 0;
    idling_on = 1'b1;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= srts_pkg::ACT_LOAD;
    entry_index <= '0;
    arrival_time <= '0;
    burst_time <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    tick_job();
    load_job(4'd0, 16'd0, 16'd3);
    load_job(4'd1, 16'd0, 16'd3);
    load_job(4'd2, 16'd1, 16'd1);
    load_job(4'd3, 16'd0, 16'd0);
    load_job(4'd15, 16'hFFFF, 16'hFFFF);
    send_item(ACT_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
    repeat (6) tick_job();
    load_job(4'd4, 16'd0, 16'd2);
    repeat (3) tick_job();
    restart_jobs();
    repeat (3) tick_job();
    write_count(srts_pkg::pcount_t'(0));
    repeat (2) tick_job();
    write_count(srts_pkg::pcount_t'(31));
    repeat (2) tick_job();
    write_count(srts_pkg::pcount_t'(1));
    repeat (2) tick_job();
    write_count(srts_pkg::pcount_t'(16));
    tick_job();

    while (items_sent < ITEM_GOAL) run_schedule();

    idling_on = 1'b0;
    write_count(srts_pkg::pcount_t'(4));
    load_job(4'd0, 16'd0, 16'd5);
    load_job(4'd1, 16'd2, 16'd2);
    load_job(4'd2, 16'd3, 16'd1);
    load_job(4'd3, 16'd4, 16'd0);
    restart_jobs();
    while (!sb.all_jobs_done()) tick_job();
    tick_job();

    settle();
    $display("Ran %0d ticks (%0d idle, %0d completions), %0d loads, %0d restarts.",
             sb.ticks, sb.idles, sb.finishes, sb.loads, sb.restarts);
    $display("Used %0d count settings, including zero, one, sixteen and 31.",
             cfg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
